[hw/rtl/isf_pkg.sv]
// constants, types and cordic angle table for the interrupted sinusoidal forward block
// no dependencies
`default_nettype none

package isf_pkg;

  localparam int FRAC_BITS  = 29;
  localparam int COS_STAGES = 28;
  localparam int WORK_BITS  = 61;
  localparam int ALIGN      = WORK_BITS - FRAC_BITS;
  localparam int SHIFT_W    = $clog2(COS_STAGES);

  localparam logic [63:0] PI_W   = 64'h6487ED5110B4611A;
  localparam logic [63:0] GAIN_W = 64'd1400229935014726477;
  localparam logic [63:0] PI60_W = PI_W / 64'd60;

  // q61 value rounded to nearest into the q29 format
  function automatic logic signed [32:0] round_fmt(input logic [63:0] w);
    logic [63:0] r;
    begin
      r = (w + (64'd1 << (ALIGN - 1))) >> ALIGN;
      return $signed(r[32:0]);
    end
  endfunction

  localparam logic signed [32:0] HALF_PI   = round_fmt(PI_W >> 1);
  localparam logic signed [32:0] PI_F      = round_fmt(PI_W);
  localparam logic signed [32:0] WEST_EDGE = -round_fmt(64'd6 * PI60_W);
  localparam logic signed [32:0] SOUTH_MID = round_fmt(64'd20 * PI60_W);
  localparam logic signed [32:0] CM_WEST   = -round_fmt(64'd33 * PI60_W);
  localparam logic signed [32:0] CM_SOUTH  = round_fmt(64'd7 * PI60_W);
  localparam logic signed [32:0] CM_EAST   = round_fmt(64'd40 * PI60_W);
  localparam logic signed [32:0] CM_NORTH  = round_fmt(64'd27 * PI60_W);

  typedef logic [63:0] atan_tab_t [COS_STAGES];

  // atan(2^-i) in q61, truncated power series, pi/4 for the first entry
  function automatic atan_tab_t build_atan();
    atan_tab_t   t;
    logic [63:0] acc;
    logic [63:0] term;
    int          n;
    begin
      for (int i = 0; i < COS_STAGES; i++) begin
        if (i == 0) begin
          t[i] = PI_W >> 2;
        end else begin
          acc = 64'd0;
          for (int k = 0; k < 64; k++) begin
            n = i * (2 * k + 1);
            if (n <= WORK_BITS) begin
              term = (64'd1 << (WORK_BITS - n)) / 64'(2 * k + 1);
              if ((k % 2) == 1) acc = acc - term;
              else              acc = acc + term;
            end
          end
          t[i] = acc;
        end
      end
      return t;
    end
  endfunction

  localparam atan_tab_t ATAN = build_atan();

  // data that rides along the rotation chain
  typedef struct packed {
    logic                 inv;
    logic [31:0]          lat;
    logic signed [32:0]   diff;
    logic signed [32:0]   central;
  } side_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    side_t              side;
  } cell_t;

endpackage

`default_nettype wire

[hw/rtl/isf_cell.sv]
// one rotation stage of the cosine cordic chain
// depends on isf_pkg
`default_nettype none

module isf_cell
  import isf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [SHIFT_W-1:0] shift,
  input  wire logic [63:0]        atan,
  input  wire logic               in_vld,
  input  wire cell_t              in_data,
  output logic                    out_vld,
  output cell_t                   out_data
);

  cell_t              data_next;
  logic signed [63:0] dx;
  logic signed [63:0] dy;

  always_comb begin
    dx        = in_data.y >>> shift;
    dy        = in_data.x >>> shift;
    data_next = in_data;
    if (!in_data.z[63]) begin
      data_next.x = in_data.x - dx;
      data_next.y = in_data.y + dy;
      data_next.z = in_data.z - $signed(atan);
    end else begin
      data_next.x = in_data.x + dx;
      data_next.y = in_data.y - dy;
      data_next.z = in_data.z + $signed(atan);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/isf_scale.sv]
// split multiply of offset by cosine, floor to q29, add central meridian, output register
// depends on isf_pkg
`default_nettype none

module isf_scale
  import isf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_vld,
  input  wire cell_t        in_data,
  output logic              out_vld,
  output logic signed [31:0] proj_x,
  output logic signed [31:0] proj_y,
  output logic              invalid
);

  logic               mul_vld;
  logic signed [65:0] p_lo;
  logic signed [64:0] p_hi;
  side_t              mul_side;
  logic signed [97:0] prod;
  logic [31:0]        x_sum;

  // cosine split into unsigned low half and signed high half
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (en) begin
      mul_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo     <= in_data.side.diff * $signed({1'b0, in_data.x[31:0]});
      p_hi     <= in_data.side.diff * $signed(in_data.x[63:32]);
      mul_side <= in_data.side;
    end
  end

  always_comb begin
    prod  = {{1{p_hi[64]}}, p_hi, 32'd0} + {{32{p_lo[65]}}, p_lo};
    x_sum = prod[WORK_BITS+31:WORK_BITS] + mul_side.central[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      invalid <= mul_side.inv;
      proj_x  <= mul_side.inv ? 32'sd0 : $signed(x_sum);
      proj_y  <= mul_side.inv ? 32'sd0 : $signed(mul_side.lat);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/interrupted_sinusoidal_forward_top.sv]
// top level of the interrupted sinusoidal forward projection
// depends on isf_pkg, isf_cell, isf_scale
//
// input channel: latitude and longitude in radians, signed q29, one transfer per point
// output channel: proj_x, proj_y (signed q29) and the invalid flag
// both channels use valid/ready; a transfer happens when valid and ready are both high
// throughput: one point per cycle, sustained while the receiver keeps out_ready high
// pipeline stages from input transfer to out_valid:
//   1 input register, COS_STAGES (28) cordic rotation cells, 1 multiply stage,
//   1 output register
// the whole pipeline moves as one: it advances whenever the output register is
//   empty or its result is being taken; while the receiver stalls with a result
//   waiting, in_ready drops and every stage holds its contents
// reset (rst, synchronous) clears all valid flags; data registers are not cleared
// out of range points (|lat| > pi/2 or |lon| > pi) come out with invalid set
//   and zero coordinates, in order with the rest
`default_nettype none

module interrupted_sinusoidal_forward_top
  import isf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] latitude,
  input  wire logic signed [31:0] longitude,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      proj_x,
  output logic signed [31:0]      proj_y,
  output logic                    invalid
);

  // global advance: output register free or draining this cycle
  logic advance;

  // input register
  logic               in_vld;
  logic signed [31:0] lat_q;
  logic signed [31:0] lon_q;

  // lobe decode on the registered point
  logic signed [32:0] lat_w;
  logic signed [32:0] lon_w;
  logic signed [32:0] alat;
  logic signed [32:0] alon;
  logic signed [32:0] central;
  logic [63:0]        z_init;
  cell_t              head;

  // rotation chain
  logic  chain_vld [COS_STAGES+1];
  cell_t chain     [COS_STAGES+1];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (advance) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lat_q <= latitude;
      lon_q <= longitude;
    end
  end

  always_comb begin
    lat_w = {lat_q[31], lat_q};
    lon_w = {lon_q[31], lon_q};
    alat  = lat_w[32] ? -lat_w : lat_w;
    alon  = lon_w[32] ? -lon_w : lon_w;

    // west lobe is shared by both hemispheres; zero latitude counts as north
    if (lon_w < WEST_EDGE) begin
      central = CM_WEST;
    end else if (lat_w[32]) begin
      central = (lon_w < SOUTH_MID) ? CM_SOUTH : CM_EAST;
    end else begin
      central = CM_NORTH;
    end

    // |lat| into q61 as the angle the cordic drives to zero
    z_init = {alat[63-ALIGN:0], {ALIGN{1'b0}}};

    head.x            = $signed(GAIN_W);
    head.y            = 64'sd0;
    head.z            = $signed(z_init);
    head.side.inv     = (alat > HALF_PI) || (alon > PI_F);
    head.side.lat     = lat_q;
    head.side.diff    = lon_w - central;
    head.side.central = central;
  end

  assign chain_vld[0] = in_vld;
  assign chain[0]     = head;

  for (genvar i = 0; i < COS_STAGES; i++) begin : g_cell
    isf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .shift    (SHIFT_W'(i)),
      .atan     (ATAN[i]),
      .in_vld   (chain_vld[i]),
      .in_data  (chain[i]),
      .out_vld  (chain_vld[i+1]),
      .out_data (chain[i+1])
    );
  end

  // x = (lon - central) * cos(lat) + central, y = lat
  isf_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_vld  (chain_vld[COS_STAGES]),
    .in_data (chain[COS_STAGES]),
    .out_vld (out_valid),
    .proj_x  (proj_x),
    .proj_y  (proj_y),
    .invalid (invalid)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for interrupted_sinusoidal_forward_top
// holds its own fixed-point projection predictor, cordic included; needs only the rtl
// random idling on both channels, one long output stall, random and corner-case points

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // number formats and constants, built here independently of the rtl package
  localparam int WORK_FRAC = 61;
  localparam int PT_FRAC   = 29;
  localparam int ROT_STEPS = 28;
  localparam int LATENCY   = 31;
  localparam int MAX_WAIT  = 12;
  localparam int HOLD_AT   = 300;   // accepted points before the long output stall
  localparam int HOLD_LEN  = 200;   // cycles of that stall, well past the pipeline depth
  localparam int N_RANDOM  = 1600;

  localparam logic [63:0] PI_Q61   = 64'h6487ED5110B4611A;
  localparam longint      GAIN_Q61 = 64'sd1400229935014726477;
  localparam logic [63:0] STEP_Q61 = PI_Q61 / 64'd60;

  // q61 to q29, round to nearest
  function automatic longint to_q29(input logic [63:0] w);
    return longint'((w + (64'd1 << (WORK_FRAC - PT_FRAC - 1))) >> (WORK_FRAC - PT_FRAC));
  endfunction

  localparam longint HALF_PI_Q29 = to_q29(PI_Q61 >> 1);
  localparam longint PI_Q29      = to_q29(PI_Q61);
  localparam longint WEST_EDGE   = -to_q29(64'd6 * STEP_Q61);
  localparam longint SOUTH_SPLIT = to_q29(64'd20 * STEP_Q61);
  localparam longint MERID_WEST  = -to_q29(64'd33 * STEP_Q61);
  localparam longint MERID_SMID  = to_q29(64'd7 * STEP_Q61);
  localparam longint MERID_SEAST = to_q29(64'd40 * STEP_Q61);
  localparam longint MERID_NEAST = to_q29(64'd27 * STEP_Q61);

  typedef struct {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } geo_pt_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               inv;
  } plane_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic signed [31:0] latitude  = '0;
  logic signed [31:0] longitude = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] proj_x;
  logic signed [31:0] proj_y;
  logic               invalid;

  interrupted_sinusoidal_forward_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .latitude  (latitude),
    .longitude (longitude),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .proj_x    (proj_x),
    .proj_y    (proj_y),
    .invalid   (invalid)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // points waiting to be offered, and projections waiting to come out
  geo_pt_t   point_queue[$];
  plane_pt_t expected_xy[$];

  // arctangent of 2^-i in q61: pi/4 first, then the truncated power series
  logic [63:0] atan_q61 [ROT_STEPS];

  initial begin : atan_fill
    logic [63:0] acc;
    logic [63:0] term;
    int          k;
    int          n;
    atan_q61[0] = PI_Q61 >> 2;
    for (int i = 1; i < ROT_STEPS; i++) begin
      acc = '0;
      k = 0;
      n = i;
      while (n <= WORK_FRAC) begin
        term = (64'd1 << (WORK_FRAC - n)) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
        k = k + 1;
        n = i * (2 * k + 1);
      end
      atan_q61[i] = acc;
    end
  end

  // expected projection of one point
  function automatic plane_pt_t project_point(input logic signed [31:0] lat,
                                              input logic signed [31:0] lon);
    plane_pt_t          r;
    longint             la;
    longint             lo;
    longint             alat;
    longint             alon;
    longint             central;
    longint             cx;
    longint             cy;
    longint             cz;
    longint             dx;
    longint             dy;
    longint             xs;
    logic signed [127:0] pd;
    logic signed [127:0] pc;
    logic signed [127:0] prod;
    la = longint'(lat);
    lo = longint'(lon);
    alat = (la < 0) ? -la : la;
    alon = (lo < 0) ? -lo : lo;
    r.x = '0;
    r.y = '0;
    r.inv = 1'b1;
    if (alat > HALF_PI_Q29 || alon > PI_Q29) return r;

    // lobe choice: zero latitude counts as north, an edge belongs to the lobe east of it
    if (lo < WEST_EDGE)  central = MERID_WEST;
    else if (la < 0)     central = (lo < SOUTH_SPLIT) ? MERID_SMID : MERID_SEAST;
    else                 central = MERID_NEAST;

    // rotation-mode cordic driving |lat| to zero, x ends up as cos(lat) in q61
    cx = GAIN_Q61;
    cy = 0;
    cz = alat <<< (WORK_FRAC - PT_FRAC);
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - longint'(atan_q61[i]);
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + longint'(atan_q61[i]);
      end
    end

    // full-width product, floored back to q29
    pd = 128'(lo - central);
    pc = 128'(cx);
    prod = pd * pc;
    xs = longint'(prod >>> WORK_FRAC);
    r.x = 32'(xs + central);
    r.y = lat;
    r.inv = 1'b0;
    return r;
  endfunction

  // idle draw per item, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  int n_errors  = 0;
  int n_in      = 0;
  int n_out     = 0;
  int n_invalid = 0;
  int n_south   = 0;

  task automatic report(input string msg);
    n_errors++;
    if (n_errors <= 30) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic add_point(input longint la, input longint lo);
    geo_pt_t p;
    p.lat = 32'(la);
    p.lon = 32'(lo);
    point_queue.push_back(p);
  endtask

  // handshake seen at the last rising edge, used by the falling-edge drivers
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  // input driver: holds the point until its transfer, then idles for the drawn gap
  int tx_wait = 0;
  int tx_calm = 0;

  always @(negedge clk) begin : driver
    geo_pt_t p;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid || in_fire) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (point_queue.size() != 0) begin
        p = point_queue.pop_front();
        latitude <= p.lat;
        longitude <= p.lon;
        in_valid <= 1'b1;
        tx_wait <= draw_wait(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output stall, counted here in cycles once enough points have gone in
  int hold_left = 0;
  int hold_seen = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : backpressure
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (in_valid && in_ready) hold_seen <= hold_seen + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && hold_seen >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end
    end
  end

  // output side: after each transfer, ready drops for the drawn number of cycles
  int rx_wait = 0;
  int rx_calm = 0;

  always @(negedge clk) begin : receiver
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (out_fire)   w = draw_wait(rx_calm);
      else if (w > 0) w = w - 1;
      rx_wait <= w;
      out_ready <= (w == 0) && (hold_left == 0);
    end
  end

  // monitor: predict on every input transfer, check every output transfer in order
  always @(posedge clk) begin : monitor
    plane_pt_t pred;
    plane_pt_t want;
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        pred = project_point(latitude, longitude);
        expected_xy.push_back(pred);
        n_in++;
        if (pred.inv) n_invalid++;
        else if (latitude < 0) n_south++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_xy.size() == 0) begin
          report($sformatf("result x=%0d y=%0d invalid=%0b with no point outstanding",
                           proj_x, proj_y, invalid));
        end else begin
          want = expected_xy.pop_front();
          if (proj_x !== want.x)
            report($sformatf("result %0d proj_x got %0d expected %0d", n_out, proj_x, want.x));
          if (proj_y !== want.y)
            report($sformatf("result %0d proj_y got %0d expected %0d", n_out, proj_y, want.y));
          if (invalid !== want.inv)
            report($sformatf("result %0d invalid got %0b expected %0b",
                             n_out, invalid, want.inv));
        end
      end
    end
  end

  // stimulus: corner points first, then mostly in-range random points
  initial begin : stimulus
    longint la;
    longint lo;
    longint edge_pt;
    int     pick;

    // zero latitude goes north, the smallest negative one goes south
    add_point(0, 0);
    add_point(-1, 0);
    // poles and date line, still legal
    add_point(HALF_PI_Q29, PI_Q29);
    add_point(-HALF_PI_Q29, -PI_Q29);
    add_point(HALF_PI_Q29, -PI_Q29);
    add_point(-HALF_PI_Q29, PI_Q29);
    // one step out of range on each side
    add_point(HALF_PI_Q29 + 1, 0);
    add_point(-HALF_PI_Q29 - 1, 0);
    add_point(0, PI_Q29 + 1);
    add_point(0, -PI_Q29 - 1);
    // extremes of the field width
    add_point(-64'sd2147483648, -64'sd2147483648);
    add_point(64'sd2147483647, 64'sd2147483647);
    add_point(64'sd2147483647, 0);
    add_point(0, -64'sd2147483648);
    // western lobe edge, both hemispheres, on and just below
    add_point(1000, WEST_EDGE);
    add_point(1000, WEST_EDGE - 1);
    add_point(-1000, WEST_EDGE);
    add_point(-1000, WEST_EDGE - 1);
    // southern split between the middle and eastern lobes
    add_point(-1000, SOUTH_SPLIT);
    add_point(-1000, SOUTH_SPLIT - 1);
    add_point(1000, SOUTH_SPLIT);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        la = longint'($urandom_range(0, 32'(2 * HALF_PI_Q29))) - HALF_PI_Q29;
        lo = longint'($urandom_range(0, 32'(2 * PI_Q29))) - PI_Q29;
      end else if (pick < 90) begin
        // crowd the range limits and lobe edges
        case ($urandom_range(0, 4))
          0:       edge_pt = WEST_EDGE;
          1:       edge_pt = SOUTH_SPLIT;
          2:       edge_pt = PI_Q29;
          3:       edge_pt = -PI_Q29;
          default: edge_pt = 0;
        endcase
        lo = edge_pt + longint'($urandom_range(0, 8)) - 4;
        la = $urandom_range(0, 1) ? HALF_PI_Q29 : -HALF_PI_Q29;
        la = $urandom_range(0, 1) ? la + longint'($urandom_range(0, 8)) - 4
                                  : longint'($urandom_range(0, 32'(2 * HALF_PI_Q29)))
                                    - HALF_PI_Q29;
      end else begin
        la = longint'(signed'($urandom));
        lo = longint'(signed'($urandom));
      end
      add_point(la, lo);
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (point_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_xy.size() != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);

    $display("run covered %0d points: %0d out of range, %0d southern, %0d results checked",
             n_in, n_invalid, n_south, n_out);
    $display("output stall of %0d cycles %0s, %0d mismatches",
             HOLD_LEN, hold_done ? "applied" : "not reached", n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // generous ceiling on the run, far beyond every gap and stall at its worst
  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d points in, %0d results out", n_in, n_out);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
